FILE: sv/dual_hbridge_drive_guard_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual H-bridge drive guard
// Shared shorthand for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef DUAL_HBRIDGE_DRIVE_GUARD_CORE_MACROS_SVH
`define DUAL_HBRIDGE_DRIVE_GUARD_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHDG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DHDG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/dhdg_pkg.sv
// ---------------------------------------------------------------------------
// Dual H-bridge drive guard package
// Widths, register reset values, codes and shared types of the block.
// ---------------------------------------------------------------------------
package dhdg_pkg;

	// Field widths.
	localparam int unsigned DemandW = 16;
	localparam int unsigned MvW     = 16;
	localparam int unsigned AngleW  = 32;
	localparam int unsigned LimitW  = 31;
	localparam int unsigned DutyW   = 8;
	localparam int unsigned DirW    = 2;
	localparam int unsigned ProdW   = 31;
	localparam int unsigned QuotW   = 15;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 31;
	localparam int unsigned InDataW  = 88;
	localparam int unsigned OutDataW = 24;

	// Register reset values.
	localparam logic [MvW-1:0]    ResetReferenceMv   = 16'd16000;
	localparam logic [MvW-1:0]    ResetUndervoltMv   = 16'd12000;
	localparam logic [LimitW-1:0] ResetTiltLimit     = 31'd450000;
	localparam logic [MvW-1:0]    ResetRestBand      = 16'd20;
	localparam logic [DutyW-1:0]  ResetDutyLimit     = 8'd255;
	localparam logic [MvW-1:0]    ResetStartHold     = 16'd0;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_REFERENCE_MV    = 3'd0,
		REG_UNDERVOLTAGE_MV = 3'd1,
		REG_TILT_LIMIT      = 3'd2,
		REG_REST_BAND       = 3'd3,
		REG_DUTY_LIMIT      = 3'd4,
		REG_START_HOLD      = 3'd5
	} cfg_reg_t;

	// Bridge direction codes.
	typedef enum logic [DirW-1:0] {
		DIR_OFF = 2'd0,
		DIR_POS = 2'd1,
		DIR_NEG = 2'd2
	} dir_t;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [ProdW-1:0] dividend;
		logic [MvW-1:0]   divisor;
	} div_req_t;

	// Answer of the shared divider.
	typedef struct packed {
		logic             done;
		logic [QuotW-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/dual_hbridge_drive_guard_core.sv
// ---------------------------------------------------------------------------
// Dual H-bridge drive guard
// Battery-compensated drive for two motors with undervoltage latch and tilt
// cut-off.
// ---------------------------------------------------------------------------
// Each input word carries two signed demands, the battery voltage, a tilt
// angle and an override flag, and yields exactly one output word. Both
// demands are scaled by reference_mv / battery_mv with one multiplier and one
// shared restoring divider that produces one quotient bit per cycle. For
// each word the sequencer runs, per motor, a multiply step, a range check
// and a divide step, then a finish step that updates the latch, countdown
// and tilt state once the output register is free. A motor whose result
// saturates or whose battery reading is zero skips the divider. The input
// stays not ready while a word is in progress; a finished word waits in
// the output register until taken.
`include "dual_hbridge_drive_guard_core_macros.svh"

module dual_hbridge_drive_guard_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input word: demand_left[15:0], demand_right[31:16], battery_mv[47:32],
	// tilt_angle[79:48], force_enable[80], zero fill above.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dhdg_pkg::InDataW-1:0]        s_axis_tdata,
	// Output word: left_dir[1:0], left_duty[9:2], right_dir[11:10],
	// right_duty[19:12], latched_off[20], tilt_cut[21], zero fill above.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dhdg_pkg::OutDataW-1:0]       m_axis_tdata,
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dhdg_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [dhdg_pkg::CfgDatW-1:0]        cfg_data
);
	import dhdg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [MvW-1:0]    ref_mv_q;
	logic [MvW-1:0]    uv_mv_q;
	logic [LimitW-1:0] tilt_lim_q;
	logic [MvW-1:0]    band_q;
	logic [DutyW-1:0]  duty_lim_q;

	// Persistent state.
	logic              latch_q;
	logic              tilt_q;
	logic [MvW-1:0]    hold_q;

	// Captured input word.
	logic signed [DemandW-1:0] dem_l_q;
	logic signed [DemandW-1:0] dem_r_q;
	logic [MvW-1:0]            batt_q;
	logic signed [AngleW-1:0]  angle_q;
	logic                      force_q;

	// Working registers.
	logic                      sel_q;
	logic                      neg_q;
	logic [ProdW-1:0]          prod_q;
	logic signed [DemandW-1:0] pl_q;
	logic signed [DemandW-1:0] pr_q;
	logic                      div_start_q;
	logic                      m_valid_q;
	logic [OutDataW-1:0]       out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Multiply operands.
	logic signed [DemandW-1:0] dem_sel;
	logic [DemandW-1:0]        dem_mag;
	logic [2*MvW-1:0]          prod_full;

	// Scaled demand of the current motor for each path.
	logic signed [DemandW-1:0] p_sat;
	logic signed [DemandW-1:0] p_div;
	logic                      sat_hit;

	// Tick update.
	logic                      latch_n;
	logic [MvW-1:0]            hold_n;
	logic                      tilt_n;
	logic [AngleW:0]           ang_ext;
	logic [AngleW:0]           ang_abs;
	logic signed [DemandW+1:0] sum_s;
	logic signed [DemandW+1:0] band_s;
	logic signed [DemandW-1:0] pl_eff;
	logic signed [DemandW-1:0] pr_eff;
	logic [DirW+DutyW-1:0]     drv_l;
	logic [DirW+DutyW-1:0]     drv_r;
	logic                      out_free;

	// Direction and clipped duty of one bridge.
	function automatic logic [DirW+DutyW-1:0] drive_motor(
		input logic signed [DemandW-1:0] p,
		input logic                      off,
		input logic [DutyW-1:0]          lim
	);
		logic [DemandW-1:0] mag;
		dir_t               dir;
		logic [DutyW-1:0]   duty;
		mag  = p[DemandW-1] ? DemandW'(-p) : DemandW'(p);
		dir  = p[DemandW-1] ? DIR_NEG : DIR_POS;
		duty = (mag > {{(DemandW-DutyW){1'b0}}, lim}) ? lim : mag[DutyW-1:0];
		if (off || p == '0) begin
			dir  = DIR_OFF;
			duty = '0;
		end
		return {duty, dir};
	endfunction

	// Magnitude of the selected demand times the reference.
	always_comb begin
		dem_sel   = sel_q ? dem_r_q : dem_l_q;
		dem_mag   = dem_sel[DemandW-1] ? DemandW'(-dem_sel) : DemandW'(dem_sel);
		prod_full = dem_mag * ref_mv_q;
	end

	// Saturation check and signed quotient.
	always_comb begin
		sat_hit = (prod_q[ProdW-1:QuotW] >= batt_q);
		p_sat   = neg_q ? 16'sh8000 : 16'sh7FFF;
		p_div   = neg_q ? DemandW'(-{1'b0, div_rsp.quot}) : DemandW'({1'b0, div_rsp.quot});
	end

	// Latch, countdown and tilt update, then the drive outputs.
	always_comb begin
		latch_n = latch_q | (batt_q < uv_mv_q);
		hold_n  = (hold_q != '0) ? hold_q - MvW'(1) : hold_q;
		ang_ext = {angle_q[AngleW-1], angle_q};
		ang_abs = ang_ext[AngleW] ? (AngleW+1)'(-ang_ext) : ang_ext;
		sum_s   = (DemandW+2)'(pl_q) + (DemandW+2)'(pr_q);
		band_s  = signed'({2'b00, band_q});
		if (ang_abs > {2'b00, tilt_lim_q}) begin
			tilt_n = 1'b1;
		end else if (tilt_q && (sum_s < band_s) && (sum_s > -band_s) && (hold_n == '0)) begin
			tilt_n = 1'b0;
		end else begin
			tilt_n = tilt_q;
		end
		if (force_q) begin
			tilt_n = 1'b0;
		end
		pl_eff   = tilt_n ? '0 : pl_q;
		pr_eff   = tilt_n ? '0 : pr_q;
		drv_l    = drive_motor(pl_eff, latch_n, duty_lim_q);
		drv_r    = drive_motor(pr_eff, latch_n, duty_lim_q);
		out_free = !m_valid_q || m_axis_tready;
	end

	// Divider request.
	always_comb begin
		div_req.start    = div_start_q;
		div_req.dividend = prod_q;
		div_req.divisor  = batt_q;
	end

	dhdg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			div_start_q <= 1'b0;
			m_valid_q   <= 1'b0;
			latch_q     <= 1'b0;
			tilt_q      <= 1'b0;
			hold_q      <= ResetStartHold;
			ref_mv_q    <= ResetReferenceMv;
			uv_mv_q     <= ResetUndervoltMv;
			tilt_lim_q  <= ResetTiltLimit;
			band_q      <= ResetRestBand;
			duty_lim_q  <= ResetDutyLimit;
		end else begin
			div_start_q <= 1'b0;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			// Configuration writes arrive only while idle.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_REFERENCE_MV:    ref_mv_q   <= cfg_data[MvW-1:0];
					REG_UNDERVOLTAGE_MV: uv_mv_q    <= cfg_data[MvW-1:0];
					REG_TILT_LIMIT:      tilt_lim_q <= cfg_data[LimitW-1:0];
					REG_REST_BAND:       band_q     <= cfg_data[MvW-1:0];
					REG_DUTY_LIMIT:      duty_lim_q <= cfg_data[DutyW-1:0];
					REG_START_HOLD:      hold_q     <= cfg_data[MvW-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					sel_q <= 1'b0;
					if (s_axis_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (batt_q == '0 || sat_hit) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? ST_FINISH : ST_MUL;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? ST_FINISH : ST_MUL;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						latch_q   <= latch_n;
						hold_q    <= hold_n;
						tilt_q    <= tilt_n;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			dem_l_q <= s_axis_tdata[15:0];
			dem_r_q <= s_axis_tdata[31:16];
			batt_q  <= s_axis_tdata[47:32];
			angle_q <= s_axis_tdata[79:48];
			force_q <= s_axis_tdata[80];
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[ProdW-1:0];
			neg_q  <= dem_sel[DemandW-1];
		end
		if (state_q == ST_CHECK && (batt_q == '0 || sat_hit)) begin
			if (sel_q) begin
				pr_q <= (batt_q == '0) ? '0 : p_sat;
			end else begin
				pl_q <= (batt_q == '0) ? '0 : p_sat;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (sel_q) begin
				pr_q <= p_div;
			end else begin
				pl_q <= p_div;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= {2'b00, tilt_n, latch_n, drv_r, drv_l};
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	// The undervoltage latch never clears outside reset.
	`DHDG_ASSERT_NEXT(a_latch_sticky, clk, arst_n, latch_q, latch_q, "undervoltage latch cleared")
	// A latched or tilt-cut word drives both bridges off.
	`DHDG_ASSERT_IMPL(a_off_when_cut, clk, arst_n, m_valid_q && (out_q[20] || out_q[21]), out_q[19:0] == '0, "bridge driven while cut off")
	// The divider only finishes while the sequencer waits for it.
	`DHDG_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_rsp.done, state_q == ST_DIV, "divider result outside wait state")

endmodule

FILE: sv/dhdg_div.sv
// ---------------------------------------------------------------------------
// Shared restoring divider
// Produces a 15-bit quotient, one bit per cycle. The caller guarantees that
// the upper 16 dividend bits are below the divisor, so the quotient fits.
// ---------------------------------------------------------------------------
module dhdg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dhdg_pkg::div_req_t req,
	output dhdg_pkg::div_rsp_t rsp
);
	import dhdg_pkg::*;

	logic [MvW-1:0]   rem_q;
	logic [QuotW-1:0] dvd_q;
	logic [QuotW-1:0] quot_q;
	logic [MvW-1:0]   dsr_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MvW:0]     trial;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[QuotW-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QuotW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[ProdW-1:QuotW];
			dvd_q <= req.dividend[QuotW-1:0];
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? MvW'(trial - {1'b0, dsr_q}) : trial[MvW-1:0];
			dvd_q  <= {dvd_q[QuotW-2:0], 1'b0};
			quot_q <= {quot_q[QuotW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: bench/drive_guard_checker.sv
// ---------------------------------------------------------------------------
// Drive guard result checker
// Watches the input, output and configuration channels of the dual H-bridge
// drive guard. It predicts one drive word for every accepted input word and
// compares each returned word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module drive_guard_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [dhdg_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [dhdg_pkg::OutDataW-1:0] m_axis_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [dhdg_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dhdg_pkg::CfgDatW-1:0]  cfg_data,
	output int unsigned                   outstanding,
	output int unsigned                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import dhdg_pkg::*;

	localparam int unsigned ReportLimit = 10;

	// Output word fields, listed from the highest bit down.
	typedef struct packed {
		logic             tilt_cut;
		logic             latched_off;
		logic [DutyW-1:0] right_duty;
		dir_t             right_dir;
		logic [DutyW-1:0] left_duty;
		dir_t             left_dir;
	} drive_word_t;

	// Shadow copy of the configuration registers.
	logic [MvW-1:0]    nominal_mv;
	logic [MvW-1:0]    trip_mv;
	logic [LimitW-1:0] angle_limit;
	logic [MvW-1:0]    rest_window;
	logic [DutyW-1:0]  duty_ceiling;

	// Shadow copy of the guard state.
	logic              supply_latched;
	logic              tilt_tripped;
	logic [MvW-1:0]    hold_remaining;

	drive_word_t drive_words_due[$];
	int unsigned errors_seen;

	// Demand scaled by nominal over measured voltage, truncated toward zero
	// and saturated to 16 bits. A dead battery reading gives no drive.
	function automatic int scale_demand(input logic signed [DemandW-1:0] demand,
			input logic [MvW-1:0] batt);
		longint q;
		if (batt == '0) begin
			return 0;
		end
		q = (longint'(demand) * longint'(nominal_mv)) / longint'(batt);
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		return int'(q);
	endfunction

	// Direction and duty of one bridge for a scaled demand.
	function automatic void bridge_leg(input int power, output dir_t dir,
			output logic [DutyW-1:0] duty);
		int mag;
		if (supply_latched || power == 0) begin
			dir = DIR_OFF;
			duty = '0;
			return;
		end
		dir = (power > 0) ? DIR_POS : DIR_NEG;
		mag = (power > 0) ? power : -power;
		if (mag > int'(duty_ceiling)) begin
			mag = int'(duty_ceiling);
		end
		duty = mag[DutyW-1:0];
	endfunction

	// One control tick: updates the guard state and returns the drive word.
	function automatic drive_word_t predict_drive(input logic [InDataW-1:0] w);
		logic signed [DemandW-1:0] dl;
		logic signed [DemandW-1:0] dr;
		logic [MvW-1:0]            batt;
		logic signed [AngleW-1:0]  angle;
		logic                      force_en;
		int                        pl;
		int                        pr;
		int                        sum_p;
		longint                    lim;
		dir_t                      d_l;
		dir_t                      d_r;
		logic [DutyW-1:0]          u_l;
		logic [DutyW-1:0]          u_r;
		drive_word_t               r;
		dl = w[15:0];
		dr = w[31:16];
		batt = w[47:32];
		angle = w[79:48];
		force_en = w[80];
		pl = scale_demand(dl, batt);
		pr = scale_demand(dr, batt);
		if (batt < trip_mv) begin
			supply_latched = 1'b1;
		end
		if (hold_remaining != '0) begin
			hold_remaining = hold_remaining - 1'b1;
		end
		// Tilt past the limit trips the cut-off; it clears only at rest
		// once the start-up countdown has run out.
		sum_p = pl + pr;
		lim = longint'(angle_limit);
		if (longint'(angle) > lim || longint'(angle) < -lim) begin
			tilt_tripped = 1'b1;
		end else if (tilt_tripped && sum_p < int'(rest_window) &&
				sum_p > -int'(rest_window) && hold_remaining == '0) begin
			tilt_tripped = 1'b0;
		end
		if (force_en) begin
			tilt_tripped = 1'b0;
		end
		if (tilt_tripped) begin
			pl = 0;
			pr = 0;
		end
		bridge_leg(pl, d_l, u_l);
		bridge_leg(pr, d_r, u_r);
		r.left_dir = d_l;
		r.left_duty = u_l;
		r.right_dir = d_r;
		r.right_duty = u_r;
		r.latched_off = supply_latched;
		r.tilt_cut = tilt_tripped;
		return r;
	endfunction

	// Register writes; indexes beyond the list are ignored.
	function automatic void apply_write(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDatW-1:0] value);
		case (idx)
			REG_REFERENCE_MV: begin
				nominal_mv = value[MvW-1:0];
			end
			REG_UNDERVOLTAGE_MV: begin
				trip_mv = value[MvW-1:0];
			end
			REG_TILT_LIMIT: begin
				angle_limit = value[LimitW-1:0];
			end
			REG_REST_BAND: begin
				rest_window = value[MvW-1:0];
			end
			REG_DUTY_LIMIT: begin
				duty_ceiling = value[DutyW-1:0];
			end
			REG_START_HOLD: begin
				hold_remaining = value[MvW-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Follow the three channels at every rising edge. Results are retired
	// before new predictions are queued so a stray word is never matched
	// against a prediction made in the same cycle.
	always @(posedge clk or negedge arst_n) begin : track
		drive_word_t got_w;
		drive_word_t want_w;
		logic        bad;
		if (!arst_n) begin
			nominal_mv = ResetReferenceMv;
			trip_mv = ResetUndervoltMv;
			angle_limit = ResetTiltLimit;
			rest_window = ResetRestBand;
			duty_ceiling = ResetDutyLimit;
			hold_remaining = ResetStartHold;
			supply_latched = 1'b0;
			tilt_tripped = 1'b0;
			drive_words_due.delete();
			errors_seen = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_w = drive_word_t'(m_axis_tdata[$bits(drive_word_t)-1:0]);
				if (drive_words_due.size() == 0) begin
					errors_seen++;
					if (errors_seen <= ReportLimit) begin
						$display("ERROR: drive word %h at %0t with nothing expected",
							m_axis_tdata, $realtime);
					end
				end else begin
					want_w = drive_words_due.pop_front();
					bad = (got_w.left_dir !== want_w.left_dir) ||
						(got_w.left_duty !== want_w.left_duty) ||
						(got_w.right_dir !== want_w.right_dir) ||
						(got_w.right_duty !== want_w.right_duty) ||
						(got_w.latched_off !== want_w.latched_off) ||
						(got_w.tilt_cut !== want_w.tilt_cut);
					if (bad) begin
						errors_seen++;
						if (errors_seen <= ReportLimit) begin
							$display("ERROR: drive word at %0t: expected ", $realtime,
								"ldir=%0d lduty=%0d ", want_w.left_dir, want_w.left_duty,
								"rdir=%0d rduty=%0d ", want_w.right_dir, want_w.right_duty,
								"latch=%b cut=%b, ", want_w.latched_off, want_w.tilt_cut,
								"got ldir=%0d lduty=%0d ", got_w.left_dir, got_w.left_duty,
								"rdir=%0d rduty=%0d ", got_w.right_dir, got_w.right_duty,
								"latch=%b cut=%b", got_w.latched_off, got_w.tilt_cut);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				drive_words_due.push_back(predict_drive(s_axis_tdata));
			end
			outstanding <= drive_words_due.size();
			fail_count <= errors_seen;
		end
	end

endmodule

FILE: bench/dual_hbridge_drive_guard_core_tb.sv
// ---------------------------------------------------------------------------
// Dual H-bridge drive guard testbench
// Drives control ticks and register writes into the drive guard with random
// gaps and output stalls, one long output hold-off that backs up the input,
// and a final phase that trips the undervoltage latch. A separate checker
// predicts and compares every drive word.
// ---------------------------------------------------------------------------
module dual_hbridge_drive_guard_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dhdg_pkg::*;

	localparam int unsigned CycleLimit    = 400000;
	localparam int unsigned HoldOffCycles = 400;
	localparam int unsigned TailCycles    = 60;
	localparam int unsigned RandomPhases  = 8;
	localparam int unsigned PhaseTicks    = 50;
	localparam int unsigned LatchTicks    = 25;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDatW-1:0]  cfg_data;
	int unsigned         outstanding;
	int unsigned         fail_count;

	// Stimulus shaping shared between the source and the sink.
	logic              no_idle = 1'b0;
	logic              pressure_on = 1'b0;
	logic              pressure_done = 1'b0;
	logic [MvW-1:0]    cur_uv = ResetUndervoltMv;
	logic [LimitW-1:0] cur_limit = ResetTiltLimit;

	dual_hbridge_drive_guard_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	drive_guard_checker guard_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit in case the block hangs.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Output sink: random stalls, mostly short, plus one long hold-off while
	// the source keeps offering words.
	initial begin : sink
		int unsigned stall_left;
		int unsigned r;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && !pressure_done) begin
				m_axis_tready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				pressure_done = 1'b1;
			end
			if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(2) : $urandom_range(40, 15);
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 65) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 12);
	endfunction

	function automatic logic [InDataW-1:0] pack_tick(input logic [DemandW-1:0] dl,
			input logic [DemandW-1:0] dr, input logic [MvW-1:0] batt,
			input logic [AngleW-1:0] angle, input logic force_en);
		logic [InDataW-1:0] w;
		w = '0;
		w[15:0] = dl;
		w[31:16] = dr;
		w[47:32] = batt;
		w[79:48] = angle;
		w[80] = force_en;
		return w;
	endfunction

	// Demands: full range, near rest, around the duty limit, and extremes.
	function automatic logic [DemandW-1:0] pick_demand();
		int unsigned r;
		int          v;
		r = $urandom_range(99);
		if (r < 35) begin
			return DemandW'($urandom);
		end
		if (r < 55) begin
			v = $urandom_range(8);
		end else if (r < 65) begin
			case ($urandom_range(4))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'hFFFF;
				3: return 16'h0001;
				default: return 16'h0000;
			endcase
		end else begin
			v = $urandom_range(400);
		end
		if ($urandom_range(1) == 1) begin
			v = -v;
		end
		return DemandW'(v);
	endfunction

	// Angles: mostly inside the current limit, some on its edges, some
	// anywhere in the 32-bit range.
	function automatic logic [AngleW-1:0] pick_angle();
		int unsigned       r;
		logic [AngleW-1:0] mag;
		r = $urandom_range(99);
		if (r < 75) begin
			mag = $urandom_range(cur_limit);
			return ($urandom_range(1) == 1) ? -mag : mag;
		end
		if (r < 85) begin
			mag = {1'b0, cur_limit};
			case ($urandom_range(3))
				0: return mag;
				1: return mag + 1'b1;
				2: return -mag;
				default: return -mag - 1'b1;
			endcase
		end
		return $urandom();
	endfunction

	// Offer one tick word and hold it until the block takes it.
	task automatic send_tick(input logic [InDataW-1:0] w);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= w;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Battery stays at or above the given floor so the latch holds off.
	task automatic random_ticks(input int unsigned count, input logic [MvW-1:0] floor_mv);
		logic [MvW-1:0] batt;
		for (int unsigned i = 0; i < count; i++) begin
			if (floor_mv == '0 && $urandom_range(19) == 0) begin
				batt = '0;
			end else if ($urandom_range(9) == 0) begin
				batt = ($urandom_range(1) == 1) ? 16'hFFFF : floor_mv;
			end else begin
				batt = MvW'($urandom_range(16'hFFFF, floor_mv));
			end
			send_tick(pack_tick(pick_demand(), pick_demand(), batt, pick_angle(),
				$urandom_range(9) == 0));
		end
	endtask

	// Stop offering and wait until every drive word has come back.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [CfgDatW-1:0] pad_upper(input logic [CfgDatW-1:0] value,
			input int unsigned width);
		logic [CfgDatW-1:0] junk;
		junk = CfgDatW'($urandom);
		if (width >= CfgDatW) begin
			return value;
		end
		return value | (junk << width);
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register, with junk above each field narrower than the bus,
	// plus one write to an unused index that must change nothing.
	task automatic set_config(input logic [MvW-1:0] nominal_v, input logic [MvW-1:0] uv_v,
			input logic [LimitW-1:0] lim_v, input logic [MvW-1:0] band_v,
			input logic [DutyW-1:0] duty_v, input logic [MvW-1:0] hold_v);
		logic [CfgIdxW-1:0] unused_idx;
		unused_idx = CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, int'(REG_START_HOLD) + 1));
		write_reg(REG_REFERENCE_MV, pad_upper(nominal_v, MvW));
		write_reg(REG_UNDERVOLTAGE_MV, pad_upper(uv_v, MvW));
		write_reg(unused_idx, CfgDatW'($urandom));
		write_reg(REG_TILT_LIMIT, pad_upper(lim_v, LimitW));
		write_reg(REG_REST_BAND, pad_upper(band_v, MvW));
		write_reg(REG_DUTY_LIMIT, pad_upper(duty_v, DutyW));
		write_reg(REG_START_HOLD, pad_upper(hold_v, MvW));
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_uv = uv_v;
		cur_limit = lim_v;
	endtask

	initial begin : stimulus
		logic [MvW-1:0]    nominal_v;
		logic [MvW-1:0]    uv_v;
		logic [LimitW-1:0] lim_v;
		logic [MvW-1:0]    band_v;
		logic [DutyW-1:0]  duty_v;
		logic [MvW-1:0]    hold_v;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero drive, saturation both ways, exact scaling,
		// truncation to zero, tilt on and just past both limits, rest band
		// edges, the full angle range and the override.
		send_tick(pack_tick(16'd0, 16'd0, 16'd12000, 32'd0, 1'b0));
		send_tick(pack_tick(16'h7FFF, 16'h8000, 16'd12000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd100, -16'd100, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(-16'd1, 16'd1, 16'hFFFF, 32'd0, 1'b0));
		send_tick(pack_tick(16'd1000, 16'd1000, 16'd32000, 32'd450000, 1'b0));
		send_tick(pack_tick(16'd1000, 16'd1000, 16'd32000, 32'd450001, 1'b0));
		send_tick(pack_tick(16'd1000, 16'd0, 16'd32000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd5, 16'd5, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd0, 16'd0, 16'd16000, -32'd450001, 1'b0));
		send_tick(pack_tick(16'd20, 16'd0, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(-16'd19, 16'd0, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd0, 16'd0, 16'd16000, 32'h8000_0000, 1'b0));
		send_tick(pack_tick(16'd300, -16'd300, 16'd16000, 32'h7FFF_FFFF, 1'b1));
		send_tick(pack_tick(16'h8000, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));

		// A start-up countdown of three holds the cut-off at rest until it has run
		// out, then a dead battery reading and a zero duty limit.
		settle();
		set_config(16'd16000, 16'd0, 31'd450000, 16'd20, 8'd0, 16'd3);
		send_tick(pack_tick(16'd0, 16'd0, 16'd16000, 32'd450001, 1'b0));
		send_tick(pack_tick(16'd1, 16'd1, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd1, 16'd1, 16'd16000, 32'd0, 1'b0));
		send_tick(pack_tick(16'd1234, -16'd1234, 16'd0, 32'd0, 1'b0));
		send_tick(pack_tick(16'd500, -16'd500, 16'd16000, 32'd0, 1'b0));

		// Random phases, each with its own register settings.
		for (int unsigned p = 0; p < RandomPhases; p++) begin
			settle();
			nominal_v = (p == 0) ? 16'd16000 : (p == 1) ? 16'd0 :
				(p == 2) ? 16'hFFFF : MvW'($urandom);
			uv_v = (p % 3 == 0) ? 16'd0 : MvW'($urandom_range(20000));
			lim_v = (p == 3) ? '0 : (p == 4) ? 31'h7FFF_FFFF : LimitW'($urandom);
			band_v = (p == 5) ? 16'd0 : (p == 6) ? 16'hFFFF : MvW'($urandom_range(200));
			duty_v = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : DutyW'($urandom);
			hold_v = (p == 0) ? 16'd0 : (p == 7) ? 16'hFFFF : MvW'($urandom_range(20));
			set_config(nominal_v, uv_v, lim_v, band_v, duty_v, hold_v);
			no_idle = (p == 0 || p == 5);
			if (p == 3) begin
				pressure_on = 1'b1;
			end
			random_ticks(PhaseTicks, cur_uv);
		end

		// Undervoltage trips the latch, which then keeps both bridges off.
		settle();
		no_idle = 1'b0;
		set_config(MvW'($urandom), 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 8'd255, 16'd0);
		send_tick(pack_tick(16'd200, -16'd200, 16'hFFFF, 32'd0, 1'b0));
		random_ticks(LatchTicks, 16'd0);

		settle();
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/dhdg_pkg.sv
sv/dhdg_div.sv
sv/dual_hbridge_drive_guard_core.sv
bench/drive_guard_checker.sv
bench/dual_hbridge_drive_guard_core_tb.sv
